@@ rtl/core/window_gradient_coherence_ratio_core_defines.svh @@
// Assertion macros shared by the window gradient coherence ratio RTL.
// Each macro expects clk and rst in scope; NO_ASSERTIONS compiles them out.
`ifndef WINDOW_GRADIENT_COHERENCE_RATIO_CORE_DEFINES_SVH
`define WINDOW_GRADIENT_COHERENCE_RATIO_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define WGCR_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define WGCR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define WGCR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define WGCR_ASSERT(label, cond, msg)
`define WGCR_ASSERT_IMP(label, ante, cons, msg)
`define WGCR_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/core/wgcr_pkg.sv @@
// Package for the window gradient coherence ratio core: widths, codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wgcr_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int MAG_FRAC        = RATIO_FRAC_BITS + 2;

  localparam int WIN          = 5;
  localparam int WIN_AREA     = WIN * WIN;
  localparam int ADDR_W       = $clog2(WIN_AREA);
  localparam int FIRST_CENTER = WIN + 1;
  localparam int LAST_CENTER  = 3 * WIN + 3;

  // gradient and norm datapath widths
  localparam int DIFF_W    = SAMPLE_BITS + 1;
  localparam int SUM_W     = SAMPLE_BITS + 5;
  localparam int NORM_IN_W = SUM_W - 1;
  localparam int SQ_W      = 2 * NORM_IN_W + 1;
  localparam int RAD_BITS  = SQ_W + 2 * MAG_FRAC;
  localparam int ROOT_W    = (RAD_BITS + 1) / 2;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 3;
  localparam int DEN_W     = ROOT_W + 4;
  localparam int RATIO_W   = RATIO_FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(ROOT_W + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t FILL_RESET = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

  // neighbor read order for one inner pixel
  localparam logic [2:0] RD_CTR  = 3'd0;
  localparam logic [2:0] RD_LF   = 3'd1;
  localparam logic [2:0] RD_RT   = 3'd2;
  localparam logic [2:0] RD_UP   = 3'd3;
  localparam logic [2:0] RD_DN   = 3'd4;
  localparam logic [2:0] RD_DONE = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/wgcr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wgcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/wgcr_norm.sv @@
// Bit-serial scaled norm: floor(sqrt((a^2 + b^2) << 2*MAG_FRAC)).
// Shift-add squarer (one operand bit per cycle), then restoring root (one bit per cycle).
`timescale 1ns / 1ps
`default_nettype none
module wgcr_norm (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [wgcr_pkg::NORM_IN_W-1:0]  a,
  input  logic [wgcr_pkg::NORM_IN_W-1:0]  b,
  output logic [wgcr_pkg::ROOT_W-1:0]     root,
  output wgcr_pkg::unit_stat_t            stat
);
  import wgcr_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_SQ   = 3'b010,
    PH_ROOT = 3'b100
  } phase_t;

  phase_t               phase;
  logic [CNT_W-1:0]     cnt;
  logic                 done;
  logic [NORM_IN_W-1:0] a_sh, b_sh, a_val, b_val;
  logic [SQ_W-1:0]      acc;
  logic [RAD_W-1:0]     rad;
  logic [REM_W-1:0]     rem;

  logic [SQ_W-1:0]  sq_add, acc_next;
  logic [REM_W-1:0] rem_sh, trial, rem_sub;
  logic             take;

  always_comb begin
    sq_add   = (a_sh[NORM_IN_W-1] ? SQ_W'(a_val) : '0) +
               (b_sh[NORM_IN_W-1] ? SQ_W'(b_val) : '0);
    acc_next = {acc[SQ_W-2:0], 1'b0} + sq_add;
    rem_sh   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial    = {1'b0, root, 2'b01};
    take     = rem_sh >= trial;
    rem_sub  = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            a_sh  <= a;
            b_sh  <= b;
            a_val <= a;
            b_val <= b;
            acc   <= '0;
            cnt   <= '0;
            phase <= PH_SQ;
          end
        end
        PH_SQ: begin
          a_sh <= {a_sh[NORM_IN_W-2:0], 1'b0};
          b_sh <= {b_sh[NORM_IN_W-2:0], 1'b0};
          acc  <= acc_next;
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(NORM_IN_W - 1)) begin
            rad   <= RAD_W'(acc_next) << (2 * MAG_FRAC);
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            phase <= PH_ROOT;
          end
        end
        PH_ROOT: begin
          rad  <= {rad[RAD_W-3:0], 2'b00};
          rem  <= take ? rem_sub : rem_sh;
          root <= {root[ROOT_W-2:0], take};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(ROOT_W - 1)) begin
            phase <= PH_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

  assign stat.busy = (phase != PH_IDLE);
  assign stat.done = done;

endmodule
`default_nettype wire

@@ rtl/core/wgcr_div.sv @@
// Restoring fraction divider, one quotient bit per cycle: num * 2^F / den, saturated at 1.0.
// Depends on wgcr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wgcr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wgcr_pkg::ROOT_W-1:0]   num,
  input  logic [wgcr_pkg::DEN_W-1:0]    den,
  output logic [wgcr_pkg::RATIO_W-1:0]  ratio,
  output logic                          zero_gradient,
  output wgcr_pkg::unit_stat_t          stat
);
  import wgcr_pkg::*;

  typedef enum logic [1:0] {
    DV_IDLE = 2'b01,
    DV_RUN  = 2'b10
  } dphase_t;

  dphase_t          phase;
  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [DEN_W-1:0] rem;

  logic [DEN_W:0] rem_sh, rem_sub;
  logic           take;

  always_comb begin
    rem_sh  = {rem, 1'b0};
    take    = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= DV_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        DV_IDLE: begin
          if (start) begin
            if (den == '0) begin
              ratio         <= '0;
              zero_gradient <= 1'b1;
              done          <= 1'b1;
            end else if (DEN_W'(num) >= den) begin
              // truncated roots can overshoot
              ratio         <= RATIO_ONE;
              zero_gradient <= 1'b0;
              done          <= 1'b1;
            end else begin
              rem           <= DEN_W'(num);
              ratio         <= '0;
              zero_gradient <= 1'b0;
              cnt           <= '0;
              phase         <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          rem   <= take ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
          ratio <= {ratio[RATIO_W-2:0], take};
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_W'(RATIO_FRAC_BITS - 1)) begin
            phase <= DV_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= DV_IDLE;
      endcase
    end
  end

  assign stat.busy = (phase != DV_IDLE);
  assign stat.done = done;

endmodule
`default_nettype wire

@@ rtl/core/window_gradient_coherence_ratio_core.sv @@
// Window gradient coherence ratio core. Takes a 5x5 window of signed samples in
// row-major order, one transfer per cycle while loading, and after the 25th sample
// returns |sum of the nine inner-pixel gradients| / sum of their magnitudes as
// unsigned Q1.16 (zero_gradient set, ratio 0, when every magnitude is zero).
// Neighbors equal to the fill value written on cfg_data are replaced by the center
// pixel. Samples load at one per cycle; then the input stalls while the window
// is processed: for each of the nine inner pixels a read pass over center, left,
// right, up and down, a gradient step and a norm wait; then a norm of the summed
// gradient and a divide wait, with no bit loop when the ratio is zero or saturated.
// Each norm runs 20 squarer steps and 39 root steps in the shared bit-serial norm
// unit, which sets the pace of each window. The result sits in an output register,
// so loading of the next window starts as soon as the divide ends; a result still
// waiting there holds the core at the divide until it is taken.
// Depends on wgcr_pkg, wgcr_ram, wgcr_norm, wgcr_div and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "window_gradient_coherence_ratio_core_defines.svh"
module window_gradient_coherence_ratio_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [wgcr_pkg::SAMPLE_BITS-1:0]    cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [wgcr_pkg::SAMPLE_BITS-1:0]    sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [wgcr_pkg::RATIO_W-1:0]        ratio,
  output logic                                zero_gradient
);
  import wgcr_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_READ = 7'b0000010,
    S_GRAD = 7'b0000100,
    S_NORM = 7'b0001000,
    S_SUM  = 7'b0010000,
    S_NUMR = 7'b0100000,
    S_DIV  = 7'b1000000
  } state_t;

  localparam logic [1:0] COL_FIRST = 2'd1;
  localparam logic [1:0] COL_LAST  = 2'd3;

  state_t                   state;
  logic [ADDR_W-1:0]        load_pos;
  sample_t                  fill_reg;
  logic [ADDR_W-1:0]        center;
  logic [1:0]               col;
  logic [2:0]               rd_cnt;
  sample_t                  taps [5];
  logic signed [SUM_W-1:0]  sx, sy;
  logic [DEN_W-1:0]         den;

  logic                     in_xfer, out_xfer, res_load;
  logic [ADDR_W-1:0]        rd_addr;
  logic [SAMPLE_BITS-1:0]   rdata;
  sample_t                  ctr, lf_f, rt_f, up_f, dn_f;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        dx_mag, dy_mag;
  logic [SUM_W-1:0]         sx_mag, sy_mag;

  logic                     norm_start;
  logic [NORM_IN_W-1:0]     norm_a, norm_b;
  logic [ROOT_W-1:0]        norm_root;
  unit_stat_t               norm_stat;
  logic                     div_start;
  logic [RATIO_W-1:0]       div_ratio;
  logic                     div_zero;
  unit_stat_t               div_stat;

  assign sample_stall = (state != S_LOAD);
  assign in_xfer      = sample_valid && !sample_stall;
  assign out_xfer     = result_valid && !result_stall;
  assign res_load     = (state == S_DIV) && !div_stat.busy && (!result_valid || !result_stall);

  always_comb begin
    case (rd_cnt)
      RD_CTR:  rd_addr = center;
      RD_LF:   rd_addr = center - 1'b1;
      RD_RT:   rd_addr = center + 1'b1;
      RD_UP:   rd_addr = center - ADDR_W'(WIN);
      RD_DN:   rd_addr = center + ADDR_W'(WIN);
      default: rd_addr = center;
    endcase
  end

  wgcr_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WIN_AREA)
  ) u_window (
    .clk  (clk),
    .we   (in_xfer),
    .waddr(load_pos),
    .wdata(sample),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // taps hold center, left, right, up, down after a read pass
  always_comb begin
    ctr    = taps[0];
    lf_f   = (taps[1] == fill_reg) ? ctr : taps[1];
    rt_f   = (taps[2] == fill_reg) ? ctr : taps[2];
    up_f   = (taps[3] == fill_reg) ? ctr : taps[3];
    dn_f   = (taps[4] == fill_reg) ? ctr : taps[4];
    dx     = DIFF_W'(rt_f) - DIFF_W'(lf_f);
    dy     = DIFF_W'(dn_f) - DIFF_W'(up_f);
    dx_mag = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    dy_mag = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    sx_mag = sx[SUM_W-1] ? SUM_W'(-sx) : SUM_W'(sx);
    sy_mag = sy[SUM_W-1] ? SUM_W'(-sy) : SUM_W'(sy);
  end

  assign norm_start = (state == S_GRAD) || (state == S_SUM);
  assign norm_a     = (state == S_SUM) ? sx_mag[NORM_IN_W-1:0] : NORM_IN_W'(dx_mag);
  assign norm_b     = (state == S_SUM) ? sy_mag[NORM_IN_W-1:0] : NORM_IN_W'(dy_mag);
  assign div_start  = (state == S_NUMR) && norm_stat.done;

  wgcr_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .start(norm_start),
    .a    (norm_a),
    .b    (norm_b),
    .root (norm_root),
    .stat (norm_stat)
  );

  wgcr_div u_div (
    .clk          (clk),
    .rst          (rst),
    .start        (div_start),
    .num          (norm_root),
    .den          (den),
    .ratio        (div_ratio),
    .zero_gradient(div_zero),
    .stat         (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_reg <= FILL_RESET;
    end else if (cfg_write) begin
      fill_reg <= sample_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      load_pos     <= '0;
      rd_cnt       <= RD_CTR;
      center       <= ADDR_W'(FIRST_CENTER);
      col          <= COL_FIRST;
      result_valid <= 1'b0;
    end else begin
      if (out_xfer && !res_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (load_pos == ADDR_W'(WIN_AREA - 1)) begin
              load_pos <= '0;
              center   <= ADDR_W'(FIRST_CENTER);
              col      <= COL_FIRST;
              rd_cnt   <= RD_CTR;
              sx       <= '0;
              sy       <= '0;
              den      <= '0;
              state    <= S_READ;
            end else begin
              load_pos <= load_pos + 1'b1;
            end
          end
        end
        S_READ: begin
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt != RD_CTR) begin
            taps[4] <= sample_t'(rdata);
            for (int i = 0; i < 4; i++) begin
              taps[i] <= taps[i+1];
            end
          end
          if (rd_cnt == RD_DONE) begin
            rd_cnt <= RD_CTR;
            state  <= S_GRAD;
          end
        end
        S_GRAD: begin
          sx    <= sx + SUM_W'(dx);
          sy    <= sy + SUM_W'(dy);
          state <= S_NORM;
        end
        S_NORM: begin
          if (norm_stat.done) begin
            den <= den + DEN_W'(norm_root);
            if (center == ADDR_W'(LAST_CENTER)) begin
              state <= S_SUM;
            end else begin
              // step to the next inner pixel, wrapping to the next row
              center <= (col == COL_LAST) ? center + 2'd3 : center + 1'b1;
              col    <= (col == COL_LAST) ? COL_FIRST : col + 1'b1;
              state  <= S_READ;
            end
          end
        end
        S_SUM: begin
          state <= S_NUMR;
        end
        S_NUMR: begin
          if (norm_stat.done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (res_load) begin
            ratio         <= div_ratio;
            zero_gradient <= div_zero;
            result_valid  <= 1'b1;
            state         <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `WGCR_ASSERT(a_load_pos_range, load_pos < ADDR_W'(WIN_AREA), "load position past window")
  `WGCR_ASSERT_IMP(a_norm_start_idle, norm_start, !norm_stat.busy, "norm started while busy")
  `WGCR_ASSERT_IMP(a_div_done_wait, div_stat.done, state == S_DIV, "divide ended outside wait")
  `WGCR_ASSERT_IMP(a_zero_ratio, result_valid && zero_gradient, ratio == '0, "flag with ratio")

endmodule
`default_nettype wire

@@ bench/window_gradient_coherence_ratio_core_test.sv @@
// Self-checking bench for window_gradient_coherence_ratio_core: random 5x5 windows,
// fill value changes between windows, random valid/stall gaps, field-by-field check.
// Depends on wgcr_pkg and the core RTL.
`timescale 1ns / 1ps
module window_gradient_coherence_ratio_core_test;
  import wgcr_pkg::*;

  typedef enum logic [1:0] {ITEM_SAMPLE, ITEM_FILL, ITEM_DRAIN} item_kind_t;
  typedef struct {
    item_kind_t kind;
    logic [SAMPLE_BITS-1:0] value;
  } pending_t;
  typedef struct {
    logic [RATIO_W-1:0] ratio;
    logic zero_gradient;
  } coherence_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [SAMPLE_BITS-1:0] cfg_data = FILL_RESET;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [RATIO_W-1:0] ratio;
  logic zero_gradient;

  window_gradient_coherence_ratio_core dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall),
    .ratio(ratio), .zero_gradient(zero_gradient)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pending_t pending_q[$];
  coherence_t coherence_q[$];
  longint win_buf[WIN_AREA];
  int unsigned load_pos = 0;
  longint cur_fill = -32768;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  logic [SAMPLE_BITS-1:0] cur_fill_next = FILL_RESET;

  // floor(sqrt((a^2 + b^2) * 2^(2*MAG_FRAC)))
  function automatic logic [63:0] scaled_norm(longint a, longint b);
    logic [127:0] x, ua, ub, tt;
    logic [63:0] r, t;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    x = (ua * ua + ub * ub) << (2 * MAG_FRAC);
    r = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      t = r | (64'd1 << bit_i);
      tt = {64'd0, t} * {64'd0, t};
      if (tt <= x) r = t;
    end
    return r;
  endfunction

  function automatic longint pick(longint v, longint ctr);
    return (v == cur_fill) ? ctr : v;
  endfunction

  function automatic coherence_t window_coherence();
    coherence_t res;
    longint sx, sy, ctr, dx, dy;
    logic [63:0] den, num, rem, q;
    sx = 0; sy = 0; den = 0; q = 0;
    for (int r = 1; r <= 3; r++) begin
      for (int c = 1; c <= 3; c++) begin
        ctr = win_buf[r*WIN + c];
        dx = pick(win_buf[r*WIN + c + 1], ctr) - pick(win_buf[r*WIN + c - 1], ctr);
        dy = pick(win_buf[(r+1)*WIN + c], ctr) - pick(win_buf[(r-1)*WIN + c], ctr);
        sx += dx;
        sy += dy;
        den += scaled_norm(dx, dy);
      end
    end
    res.zero_gradient = (den == 0);
    if (den != 0) begin
      num = scaled_norm(sx, sy);
      if (num >= den) q = 64'd1 << RATIO_FRAC_BITS;
      else begin
        rem = num;
        for (int i = 0; i < RATIO_FRAC_BITS; i++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= den) begin
            rem -= den;
            q |= 1;
          end
        end
      end
    end
    res.ratio = q[RATIO_W-1:0];
    return res;
  endfunction

  // driver
  int unsigned send_gap = 0;
  int unsigned settle = 0;
  bit send_burst = 0;
  always @(posedge clk) begin
    logic nv, nw;
    logic [SAMPLE_BITS-1:0] ns, nf;
    pending_t p;
    if (rst) begin
      sample_valid <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      nv = sample_valid;
      ns = sample;
      nw = 1'b0;
      nf = cfg_data;
      if (sample_valid && !sample_stall) begin
        nv = 1'b0;
        win_buf[load_pos] = longint'($signed(sample));
        if (load_pos == WIN_AREA - 1) begin
          load_pos = 0;
          coherence_q.push_back(window_coherence());
        end else load_pos++;
        send_gap = send_burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 99) < 3) send_burst = !send_burst;
      end
      settle = (coherence_q.size() == 0 && !nv) ? settle + 1 : 0;
      if (!nv && pending_q.size() > 0) begin
        p = pending_q[0];
        if (p.kind == ITEM_SAMPLE) begin
          if (send_gap > 0) send_gap--;
          else begin
            nv = 1'b1;
            ns = p.value;
            void'(pending_q.pop_front());
          end
        end else if (p.kind == ITEM_FILL) begin
          if (settle >= 40) begin
            nw = 1'b1;
            nf = p.value;
            cur_fill = longint'($signed(p.value));
            void'(pending_q.pop_front());
          end
        end else if (coherence_q.size() == 0) begin
          void'(pending_q.pop_front());
        end
      end
      sample_valid <= nv;
      sample <= ns;
      cfg_write <= nw;
      cfg_data <= nf;
    end
  end

  // monitor; one long hold-off early on lets the core back up into its input
  int unsigned rx_wait = 0;
  int unsigned long_hold = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    coherence_t want;
    if (rst) result_stall <= 1'b0;
    else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (coherence_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transfer: ratio=%0d zero_gradient=%0b",
                     ratio, zero_gradient);
        end else begin
          want = coherence_q.pop_front();
          if (want.ratio !== ratio || want.zero_gradient !== zero_gradient) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected ratio=%0d zero_gradient=%0b, got %0d %0b",
                       results_seen, want.ratio, want.zero_gradient, ratio, zero_gradient);
          end
        end
        rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (results_seen == 4 && !hold_done) begin
          long_hold = 4000;
          hold_done = 1;
        end
      end else if (long_hold > 0) long_hold--;
      else if (rx_wait > 0) rx_wait--;
      result_stall <= (long_hold > 0) || (rx_wait > 0);
    end
  end

  task automatic push_sample(logic [SAMPLE_BITS-1:0] v);
    pending_t p;
    p.kind = ITEM_SAMPLE;
    p.value = v;
    pending_q.push_back(p);
  endtask

  task automatic push_ctl(item_kind_t k, logic [SAMPLE_BITS-1:0] v);
    pending_t p;
    p.kind = k;
    p.value = v;
    pending_q.push_back(p);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_BITS-1:0];
  endfunction

  task automatic push_window(int unsigned style);
    longint base, sx, sy, v;
    logic [SAMPLE_BITS-1:0] fv;
    fv = cur_fill_next;
    base = $signed(16'($urandom));
    sx = $signed(16'($urandom)) >>> $urandom_range(0, 12);
    sy = $signed(16'($urandom)) >>> $urandom_range(0, 12);
    for (int i = 0; i < WIN_AREA; i++) begin
      case (style)
        0: v = $signed(16'($urandom));
        1: v = clamp16(base + sx * (i % WIN) + sy * (i / WIN) + $urandom_range(0, 4) - 2);
        2: v = ($urandom_range(0, 4) == 0) ? $signed(fv) : base;
        3: v = ($urandom_range(0, 3) == 0) ? $signed(fv) : $signed(16'($urandom));
        default: begin
          case ($urandom_range(0, 2))
            0: v = -32768;
            1: v = 32767;
            default: v = $signed(fv);
          endcase
        end
      endcase
      push_sample(clamp16(v));
    end
  endtask

  initial begin
    logic [SAMPLE_BITS-1:0] fills[6];
    fills = '{16'h7FFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h1234, 16'h8000};
    // flat window: every gradient zero
    for (int i = 0; i < WIN_AREA; i++) push_sample(16'sd5);
    push_window(4);
    for (int w = 0; w < 46; w++) begin
      if (w % 8 == 7) begin
        cur_fill_next = (w / 8 == 4) ? 16'($urandom) : fills[w / 8];
        push_ctl(ITEM_FILL, cur_fill_next);
      end
      if (w == 20) push_ctl(ITEM_DRAIN, '0);
      push_window($urandom_range(0, 4));
    end
    push_ctl(ITEM_DRAIN, '0);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0 && !sample_valid && coherence_q.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("window_gradient_coherence_ratio_core_test passed");
    else $display("window_gradient_coherence_ratio_core_test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("window_gradient_coherence_ratio_core_test failed");
    $finish;
  end
endmodule

@@ window_gradient_coherence_ratio_core.f @@
+incdir+rtl/core
rtl/core/wgcr_pkg.sv
rtl/core/wgcr_ram.sv
rtl/core/wgcr_norm.sv
rtl/core/wgcr_div.sv
rtl/core/window_gradient_coherence_ratio_core.sv
bench/window_gradient_coherence_ratio_core_test.sv
